// File: sv/sbbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbc_pkg
// Shared types and constants of the swept box brush clip unit.
// ----------------------------------------------------------------------------
package sbbc_pkg;

  localparam int MaxSides = 32;
  localparam int SideW    = $clog2(MaxSides);
  localparam int OutSideW = 5;
  localparam int MacSteps = 9;
  localparam int MacCntW  = 4;
  localparam int DivSteps = 16;
  localparam int DivCntW  = 5;

  localparam logic signed [63:0] EpsQ32  = 64'sd134217728;
  localparam logic signed [17:0] MinusOne = -18'sd65536;
  localparam logic signed [17:0] PlusOne  = 18'sd65536;

  localparam int InTdataW  = 296;
  localparam int OutTdataW = 32;

  typedef enum logic [2:0] {
    CFG_BOX_MIN_X = 3'd0,
    CFG_BOX_MIN_Y = 3'd1,
    CFG_BOX_MIN_Z = 3'd2,
    CFG_BOX_MAX_X = 3'd3,
    CFG_BOX_MAX_Y = 3'd4,
    CFG_BOX_MAX_Z = 3'd5,
    CFG_POINT     = 3'd6,
    CFG_EXTENDED  = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIST,
    ST_DIFF,
    ST_CLASS,
    ST_DIV,
    ST_UPD,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
  } div_rsp_t;

endpackage

// File: sv/sbbc_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbc_mul
// Registered 32 by 18 signed multiplier shared by all dot products.
// ----------------------------------------------------------------------------
module sbbc_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [17:0] b_i,
  output logic signed [49:0] p_o
);

  logic signed [49:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: sv/sbbc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbbc_div
// Restoring fraction divider, one quotient bit per cycle, num below den.
// ----------------------------------------------------------------------------
module sbbc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbbc_pkg::div_req_t  req_i,
  output sbbc_pkg::div_rsp_t  rsp_o
);

  logic [64:0]                  rem_q, rem_d;
  logic [63:0]                  den_q;
  logic [15:0]                  quot_q, quot_d;
  logic [sbbc_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [64:0]                  shifted;

  always_comb begin
    shifted = {rem_q[63:0], 1'b0};
    if (shifted >= {1'b0, den_q}) begin
      rem_d  = shifted - {1'b0, den_q};
      quot_d = {quot_q[14:0], 1'b1};
    end else begin
      rem_d  = shifted;
      quot_d = {quot_q[14:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == sbbc_pkg::DivCntW'(sbbc_pkg::DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.num};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: sv/swept_box_brush_clip_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_box_brush_clip_unit
// Sweeps a box or point against a convex brush given one side plane per word.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | one side plane and the sweep, tlast on the final side
//  m_axis   | out       | one clip result per brush
//  cfg      | in        | box offsets, point mode, extended mode
//
// A side steps through the MAC, DIST, DIFF, CLASS, DIV, UPD and FIN states; a
// side with a zero fraction skips DIV, and a side after an early exit goes to
// FIN at once. The shared multiplier runs nine dot-product steps and
// the divider one quotient bit per cycle. s_axis_tready is high only while the
// sequencer is idle. The final side also waits until the output register is free.
// Reset clears the brush state and the configuration registers.
module swept_box_brush_clip_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z, normal_x, normal_y,
  // normal_z, plane_dist, best_fraction_in, zero pad
  input  logic [sbbc_pkg::InTdataW-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // hit, fraction, enter_side, second_valid, second_side, start_solid,
  // all_solid, fraction_zeroed
  output logic [sbbc_pkg::OutTdataW-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_idx_i,
  input  logic [31:0]                     cfg_data_i
);

  localparam int SW = sbbc_pkg::SideW;

  // configuration
  logic signed [31:0] box_min_q [3];
  logic signed [31:0] box_max_q [3];
  logic               point_q, ext_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        box_min_q[i] <= '0;
        box_max_q[i] <= '0;
      end
      point_q <= 1'b0;
      ext_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (sbbc_pkg::cfg_idx_e'(cfg_idx_i))
        sbbc_pkg::CFG_BOX_MIN_X: box_min_q[0] <= cfg_data_i;
        sbbc_pkg::CFG_BOX_MIN_Y: box_min_q[1] <= cfg_data_i;
        sbbc_pkg::CFG_BOX_MIN_Z: box_min_q[2] <= cfg_data_i;
        sbbc_pkg::CFG_BOX_MAX_X: box_max_q[0] <= cfg_data_i;
        sbbc_pkg::CFG_BOX_MAX_Y: box_max_q[1] <= cfg_data_i;
        sbbc_pkg::CFG_BOX_MAX_Z: box_max_q[2] <= cfg_data_i;
        sbbc_pkg::CFG_POINT:     point_q      <= cfg_data_i[0];
        sbbc_pkg::CFG_EXTENDED:  ext_q        <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // latched input word
  logic signed [31:0] start_q [3];
  logic signed [31:0] end_q   [3];
  logic signed [17:0] norm_q  [3];
  logic signed [31:0] pdist_q;
  logic [16:0]        bfin_q;
  logic               last_q;

  sbbc_pkg::state_e state_q, state_d;
  logic                          in_acc;
  logic [sbbc_pkg::MacCntW-1:0]  mcnt_q;
  logic [1:0]                    macc_idx_q;
  logic                          macc_vld_q;

  // brush state
  logic signed [17:0] best_enter_q, second_enter_q, least_leave_q;
  logic [SW-1:0]      best_side_q, second_side_q, side_cnt_q;
  logic               second_seen_q, ends_out_q, starts_out_q, early_q;

  logic signed [63:0] acc_q [3];
  logic signed [63:0] dist_q, d1_q, d2_q;
  logic [63:0]        num_q, den_q;
  logic               entering_q;
  logic [15:0]        frac_q;

  logic                 out_vld_q;
  logic [sbbc_pkg::OutTdataW-1:0] out_data_q;

  assign s_axis_tready = (state_q == sbbc_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // shared multiplier operand select
  logic signed [31:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_p;
  logic [1:0]         axis_q;
  logic [1:0]         grp_q;

  always_comb begin
    mul_b = norm_q[axis_q];
    case (grp_q)
      2'd0:    mul_a = start_q[axis_q];
      2'd1:    mul_a = end_q[axis_q];
      default: mul_a = norm_q[axis_q][17] ? box_max_q[axis_q] : box_min_q[axis_q];
    endcase
  end

  sbbc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  sbbc_pkg::div_req_t div_req;
  sbbc_pkg::div_rsp_t div_rsp;

  sbbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // classification of the side from d1 and d2
  logic cls_early, cls_behind, cls_enter;
  logic signed [63:0] cls_num;
  logic [63:0]        cls_den;

  always_comb begin
    cls_early  = (d1_q > 0) && ((d2_q >= sbbc_pkg::EpsQ32) || (d2_q >= d1_q));
    cls_behind = (d1_q <= 0) && (d2_q <= 0);
    cls_enter  = d1_q > d2_q;
    cls_num    = cls_enter ? (d1_q - sbbc_pkg::EpsQ32) : (-d1_q - sbbc_pkg::EpsQ32);
    cls_den    = cls_enter ? 64'(d1_q - d2_q) : 64'(d2_q - d1_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = early_q ? sbbc_pkg::ST_FIN : sbbc_pkg::ST_MAC;
        end
      end
      sbbc_pkg::ST_MAC: begin
        if (!macc_vld_q && mcnt_q == sbbc_pkg::MacCntW'(sbbc_pkg::MacSteps)) begin
          state_d = sbbc_pkg::ST_DIST;
        end
      end
      sbbc_pkg::ST_DIST: state_d = sbbc_pkg::ST_DIFF;
      sbbc_pkg::ST_DIFF: state_d = sbbc_pkg::ST_CLASS;
      sbbc_pkg::ST_CLASS: begin
        if (cls_early || cls_behind) begin
          state_d = sbbc_pkg::ST_FIN;
        end else if (cls_num <= 0) begin
          state_d = sbbc_pkg::ST_UPD;
        end else begin
          state_d = sbbc_pkg::ST_DIV;
        end
      end
      sbbc_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_d = sbbc_pkg::ST_UPD;
        end
      end
      sbbc_pkg::ST_UPD: state_d = sbbc_pkg::ST_FIN;
      sbbc_pkg::ST_FIN: begin
        if (!last_q || !out_vld_q || m_axis_tready) begin
          state_d = sbbc_pkg::ST_IDLE;
        end
      end
      default: state_d = sbbc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    div_req.start = (state_q == sbbc_pkg::ST_CLASS) && !cls_early && !cls_behind &&
                    (cls_num > 0);
    div_req.num   = 64'(cls_num);
    div_req.den   = cls_den;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload capture and datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= s_axis_tdata[32*i +: 32];
        end_q[i]   <= s_axis_tdata[96 + 32*i +: 32];
        norm_q[i]  <= s_axis_tdata[192 + 18*i +: 18];
        acc_q[i]   <= '0;
      end
      pdist_q <= s_axis_tdata[277:246];
      bfin_q  <= s_axis_tdata[294:278];
      last_q  <= s_axis_tlast;
    end
    if (macc_vld_q) begin
      acc_q[macc_idx_q] <= acc_q[macc_idx_q] + 64'(mul_p);
    end
    if (state_q == sbbc_pkg::ST_DIST) begin
      dist_q <= point_q ? {{16{pdist_q[31]}}, pdist_q, 16'b0}
                        : {{16{pdist_q[31]}}, pdist_q, 16'b0} - acc_q[2];
    end
    if (state_q == sbbc_pkg::ST_DIFF) begin
      d1_q <= acc_q[0] - dist_q;
      d2_q <= acc_q[1] - dist_q;
    end
    if (state_q == sbbc_pkg::ST_CLASS) begin
      entering_q <= cls_enter;
      num_q      <= 64'(cls_num);
      den_q      <= cls_den;
      frac_q     <= '0;
    end
    if (state_q == sbbc_pkg::ST_DIV && div_rsp.done) begin
      frac_q <= div_rsp.quot;
    end
  end

  // multiply-accumulate sequencing; the axis steps fastest, then the operand group
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q     <= '0;
      macc_vld_q <= 1'b0;
      macc_idx_q <= '0;
      axis_q     <= '0;
      grp_q      <= '0;
    end else begin
      macc_vld_q <= 1'b0;
      if (in_acc) begin
        mcnt_q <= '0;
        axis_q <= '0;
        grp_q  <= '0;
      end else if (state_q == sbbc_pkg::ST_MAC &&
                   mcnt_q != sbbc_pkg::MacCntW'(sbbc_pkg::MacSteps)) begin
        mcnt_q     <= mcnt_q + 1'b1;
        macc_vld_q <= 1'b1;
        macc_idx_q <= grp_q;
        if (axis_q == 2'd2) begin
          axis_q <= '0;
          grp_q  <= grp_q + 1'b1;
        end else begin
          axis_q <= axis_q + 1'b1;
        end
      end
    end
  end

  // brush state and result
  logic signed [17:0] frac_s;
  logic               hit;
  logic [sbbc_pkg::OutTdataW-1:0] result;

  always_comb begin
    frac_s = {2'b00, frac_q};
    hit    = (best_enter_q < least_leave_q) && (best_enter_q > sbbc_pkg::MinusOne) &&
             (best_enter_q < $signed({1'b0, bfin_q}));
    result = '0;
    if (!early_q) begin
      if (!starts_out_q) begin
        result[29] = 1'b1;
        if (!ends_out_q) begin
          result[30] = 1'b1;
          result[31] = ext_q;
        end
      end else if (hit) begin
        result[0]     = 1'b1;
        result[17:1]  = best_enter_q[16:0];
        result[22:18] = sbbc_pkg::OutSideW'(best_side_q);
        if (second_seen_q) begin
          result[23]    = 1'b1;
          result[28:24] = sbbc_pkg::OutSideW'(second_side_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_enter_q   <= sbbc_pkg::MinusOne;
      second_enter_q <= sbbc_pkg::MinusOne;
      least_leave_q  <= sbbc_pkg::PlusOne;
      best_side_q    <= '0;
      second_side_q  <= '0;
      side_cnt_q     <= '0;
      second_seen_q  <= 1'b0;
      ends_out_q     <= 1'b0;
      starts_out_q   <= 1'b0;
      early_q        <= 1'b0;
      out_vld_q      <= 1'b0;
      out_data_q     <= '0;
    end else begin
      // A final side that finishes while the word is taken reloads the register below.
      if (out_vld_q && m_axis_tready && !(state_q == sbbc_pkg::ST_FIN && last_q)) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == sbbc_pkg::ST_CLASS) begin
        if (d2_q > 0) ends_out_q <= 1'b1;
        if (d1_q > 0) starts_out_q <= 1'b1;
        if (cls_early) early_q <= 1'b1;
      end
      if (state_q == sbbc_pkg::ST_UPD) begin
        if (entering_q) begin
          if (frac_s > best_enter_q) begin
            best_enter_q <= frac_s;
            best_side_q  <= side_cnt_q;
          end else if (frac_s > second_enter_q) begin
            second_enter_q <= frac_s;
            second_side_q  <= side_cnt_q;
            second_seen_q  <= 1'b1;
          end
        end else if (frac_s < least_leave_q) begin
          least_leave_q <= frac_s;
        end
      end
      if (state_q == sbbc_pkg::ST_FIN && state_d == sbbc_pkg::ST_IDLE) begin
        if (!last_q) begin
          side_cnt_q <= (side_cnt_q == SW'(sbbc_pkg::MaxSides - 1)) ? '0
                                                                    : side_cnt_q + 1'b1;
        end else begin
          out_vld_q      <= 1'b1;
          out_data_q     <= result;
          best_enter_q   <= sbbc_pkg::MinusOne;
          second_enter_q <= sbbc_pkg::MinusOne;
          least_leave_q  <= sbbc_pkg::PlusOne;
          best_side_q    <= '0;
          second_side_q  <= '0;
          side_cnt_q     <= '0;
          second_seen_q  <= 1'b0;
          ends_out_q     <= 1'b0;
          starts_out_q   <= 1'b0;
          early_q        <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
